// ----- rtl/btrr_pkg.sv -----
package btrr_pkg;

  localparam int PIXEL_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int TOTAL_W    = 32;
  localparam int MASK_W     = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 168;

  localparam logic [CFG_ADDR_W-1:0] REG_LOWER_BOUND   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER_BOUND   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ROW_COUNT = 2'd3;

  localparam logic signed [PIXEL_W-1:0] LOWER_BOUND_RST   = 32'sd0;
  localparam logic signed [PIXEL_W-1:0] UPPER_BOUND_RST   = 32'sd65536;
  localparam logic [COUNT_W-1:0]        ROW_WIDTH_RST     = 7'd64;
  localparam logic [COUNT_W-1:0]        MIN_ROW_COUNT_RST = 7'd7;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] lower_bound;
    logic signed [PIXEL_W-1:0] upper_bound;
    logic [COUNT_W-1:0]        row_width;
    logic [COUNT_W-1:0]        min_row_count;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]  row_mask;
    logic [COUNT_W-1:0] row_kept;
    logic               row_cleared;
    logic [TOTAL_W-1:0] total_in;
    logic [TOTAL_W-1:0] total_under;
    logic [TOTAL_W-1:0] total_over;
  } result_t;

endpackage

// ----- rtl/band_threshold_row_reject_unit.sv -----
// Band threshold with sparse-row rejection, one pixel per transfer.
// Input stream: in_tdata carries a signed Q16.16 pixel, in_tuser marks the
// first pixel of a frame and clears the frame totals and any partial row.
// Output stream: one transfer at the end of each row with the row mask, the
// kept count, the running saturating totals; out_tuser flags a sparse row.
// Config: cfg_wr_en/cfg_addr/cfg_wdata write lower bound, upper bound, row
// width and minimum row count; write only while the stream is idle.
// A row-ending pixel is held in the input register; its result is then
// registered in the result register, or in the skid entry while that waits.
// Throughput: one pixel per cycle while in_tready is high; the compare/count
// path sits between the input register and the result register.
// Stall: the result register has a one-entry skid behind it, so pixels keep
// flowing while a result waits; in_tready drops only when both hold a result.
// Reset (rst_n low, synchronous): registers go to defaults (0, 65536, 64, 7),
// row state and totals clear, both streams go empty.
module band_threshold_row_reject_unit #(
  parameter int MAX_ROW_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [btrr_pkg::PIXEL_W-1:0]          in_tdata,   // pixel_value
  input  logic                                  in_tuser,   // frame_start
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // row_mask, row_kept, total_in, total_under, total_over, zero pad
  output logic [btrr_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tuser,  // row_cleared
  input  logic                                  cfg_wr_en,
  input  logic [btrr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [btrr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  btrr_pkg::cfg_t                       cfg_r;
  logic                                 in_valid_r;
  logic signed [btrr_pkg::PIXEL_W-1:0]  pixel_r;
  logic                                 frame_start_r;
  logic                                 buf_full, advance, res_valid, out_valid;
  btrr_pkg::result_t                    res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower_bound   <= btrr_pkg::LOWER_BOUND_RST;
      cfg_r.upper_bound   <= btrr_pkg::UPPER_BOUND_RST;
      cfg_r.row_width     <= btrr_pkg::ROW_WIDTH_RST;
      cfg_r.min_row_count <= btrr_pkg::MIN_ROW_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        btrr_pkg::REG_LOWER_BOUND:   cfg_r.lower_bound   <= cfg_wdata;
        btrr_pkg::REG_UPPER_BOUND:   cfg_r.upper_bound   <= cfg_wdata;
        btrr_pkg::REG_ROW_WIDTH:     cfg_r.row_width     <= cfg_wdata[btrr_pkg::COUNT_W-1:0];
        btrr_pkg::REG_MIN_ROW_COUNT: cfg_r.min_row_count <= cfg_wdata[btrr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && !buf_full;
  assign in_tready = !in_valid_r || !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pixel_r       <= in_tdata;
      frame_start_r <= in_tuser;
    end
  end

  btrr_row_accum #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_row_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (advance),
    .pixel_value(pixel_r),
    .frame_start(frame_start_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  btrr_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_data (out_res),
    .out_ready(out_tready)
  );

  assign out_tvalid = out_valid;
  assign out_tuser  = out_res.row_cleared;
  assign out_tdata  = {1'b0, out_res.total_over, out_res.total_under, out_res.total_in,
                       out_res.row_kept, out_res.row_mask};

endmodule

// ----- rtl/btrr_row_accum.sv -----
module btrr_row_accum #(
  parameter int MAX_ROW_WIDTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  btrr_pkg::cfg_t                         cfg,
  input  logic                                   item_valid,
  input  logic signed [btrr_pkg::PIXEL_W-1:0]    pixel_value,
  input  logic                                   frame_start,
  output logic                                   res_valid,
  output btrr_pkg::result_t                      res
);

  localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int HW = $clog2(MAX_ROW_WIDTH + 1);
  localparam logic [btrr_pkg::COUNT_W-1:0] WIDTH_MAX = btrr_pkg::COUNT_W'(MAX_ROW_WIDTH);

  logic [MAX_ROW_WIDTH-1:0]     mask_r, mask_nxt, mask_base, mask_upd;
  logic [CW-1:0]                col_r, col_nxt, col_base;
  logic [HW-1:0]                hits_r, hits_nxt, hits_base, hits_upd;
  logic [btrr_pkg::TOTAL_W-1:0] sum_in_r, sum_in_nxt, sum_in_base, sum_in_upd;
  logic [btrr_pkg::TOTAL_W-1:0] sum_under_r, sum_under_nxt, sum_under_base;
  logic [btrr_pkg::TOTAL_W-1:0] sum_over_r, sum_over_nxt, sum_over_base;
  logic [btrr_pkg::TOTAL_W:0]   sum_in_wide;
  logic [btrr_pkg::COUNT_W-1:0] eff_width, kept, hits_ext;
  logic                         above_lo, below_hi, in_band, row_end, cleared;

  always_comb begin
    // frame start drops any partial row and restarts the totals
    mask_base      = frame_start ? '0 : mask_r;
    col_base       = frame_start ? '0 : col_r;
    hits_base      = frame_start ? '0 : hits_r;
    sum_in_base    = frame_start ? '0 : sum_in_r;
    sum_under_base = frame_start ? '0 : sum_under_r;
    sum_over_base  = frame_start ? '0 : sum_over_r;

    above_lo = pixel_value > cfg.lower_bound;
    below_hi = pixel_value < cfg.upper_bound;
    in_band  = above_lo && below_hi;

    mask_upd = mask_base;
    if (in_band) begin
      mask_upd = mask_base | (MAX_ROW_WIDTH'(1) << col_base);
    end
    hits_upd = hits_base + HW'(in_band);
    hits_ext = btrr_pkg::COUNT_W'(hits_upd);

    if (cfg.row_width == '0) begin
      eff_width = btrr_pkg::COUNT_W'(1);
    end else if (cfg.row_width > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = cfg.row_width;
    end
    row_end = ({1'b0, btrr_pkg::COUNT_W'(col_base)} + 8'd1) >= {1'b0, eff_width};

    cleared = (hits_ext != '0) && (hits_ext < cfg.min_row_count);
    kept    = cleared ? '0 : hits_ext;

    sum_in_wide = {1'b0, sum_in_base} + (btrr_pkg::TOTAL_W + 1)'(kept);
    sum_in_upd  = sum_in_wide[btrr_pkg::TOTAL_W] ? '1 : sum_in_wide[btrr_pkg::TOTAL_W-1:0];

    sum_under_nxt = sum_under_base;
    if (!above_lo && !(&sum_under_base)) begin
      sum_under_nxt = sum_under_base + 32'd1;
    end
    sum_over_nxt = sum_over_base;
    if (above_lo && !below_hi && !(&sum_over_base)) begin
      sum_over_nxt = sum_over_base + 32'd1;
    end

    if (row_end) begin
      mask_nxt   = '0;
      col_nxt    = '0;
      hits_nxt   = '0;
      sum_in_nxt = sum_in_upd;
    end else begin
      mask_nxt   = mask_upd;
      col_nxt    = col_base + CW'(1);
      hits_nxt   = hits_upd;
      sum_in_nxt = sum_in_base;
    end

    res_valid       = item_valid && row_end;
    res.row_mask    = cleared ? '0 : btrr_pkg::MASK_W'(mask_upd);
    res.row_kept    = kept;
    res.row_cleared = cleared;
    res.total_in    = sum_in_upd;
    res.total_under = sum_under_nxt;
    res.total_over  = sum_over_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      col_r       <= '0;
      hits_r      <= '0;
      sum_in_r    <= '0;
      sum_under_r <= '0;
      sum_over_r  <= '0;
    end else if (item_valid) begin
      mask_r      <= mask_nxt;
      col_r       <= col_nxt;
      hits_r      <= hits_nxt;
      sum_in_r    <= sum_in_nxt;
      sum_under_r <= sum_under_nxt;
      sum_over_r  <= sum_over_nxt;
    end
  end

endmodule

// ----- rtl/btrr_out_buf.sv -----
module btrr_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  btrr_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  output btrr_pkg::result_t out_data,
  input  logic              out_ready
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  btrr_pkg::result_t out_data_r, out_data_nxt;
  btrr_pkg::result_t skid_data_r, skid_data_nxt;

  // push only arrives while the skid entry is free
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt  = skid_valid_r || push;
      out_data_nxt   = skid_valid_r ? skid_data_r : push_data;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/band_threshold_checker.sv -----
`timescale 1ns / 100ps

module band_threshold_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [btrr_pkg::PIXEL_W-1:0]      in_tdata,   // pixel_value
  input  logic                              in_tuser,   // frame_start
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // row_mask, row_kept, total_in, total_under, total_over, zero pad
  input  logic [btrr_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              out_tuser,  // row_cleared
  input  logic                              cfg_wr_en,
  input  logic [btrr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [btrr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                pending
);

  localparam int PIXEL_W = btrr_pkg::PIXEL_W;
  localparam int COUNT_W = btrr_pkg::COUNT_W;
  localparam int MASK_W  = btrr_pkg::MASK_W;
  localparam int TOTAL_W = btrr_pkg::TOTAL_W;

  logic signed [PIXEL_W-1:0] band_lo, band_hi;
  logic [COUNT_W-1:0]        row_len, sparse_min;
  logic [MASK_W-1:0]         row_bits;
  logic [COUNT_W-1:0]        col, hits;
  logic [TOTAL_W-1:0]        tot_in, tot_under, tot_over;
  btrr_pkg::result_t         row_results[$];
  btrr_pkg::result_t         seen, want;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + b;
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
    end
  endtask

  // Classify one pixel and, at the row end, queue the row summary.
  task automatic take_pixel(input logic signed [PIXEL_W-1:0] v, input logic fs);
    btrr_pkg::result_t r;
    int                len;
    len = (row_len == 0) ? 1 : ((row_len > MASK_W) ? MASK_W : int'(row_len));
    if (fs) begin
      tot_in    = '0;
      tot_under = '0;
      tot_over  = '0;
      col       = '0;
      hits      = '0;
      row_bits  = '0;
    end
    if (v > band_lo) begin
      if (v < band_hi) begin
        row_bits[col[5:0]] = 1'b1;
        hits = hits + 1'b1;
      end else begin
        tot_over = sat_inc(tot_over, 1);
      end
    end else begin
      tot_under = sat_inc(tot_under, 1);
    end
    if (int'(col) + 1 < len) begin
      col = col + 1'b1;
    end else begin
      r.row_cleared = (hits != 0) && (hits < sparse_min);
      r.row_kept    = r.row_cleared ? '0 : hits;
      r.row_mask    = r.row_cleared ? '0 : row_bits;
      tot_in        = sat_inc(tot_in, btrr_pkg::TOTAL_W'(r.row_kept));
      r.total_in    = tot_in;
      r.total_under = tot_under;
      r.total_over  = tot_over;
      row_results.push_back(r);
      row_bits = '0;
      col      = '0;
      hits     = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      band_lo    = btrr_pkg::LOWER_BOUND_RST;
      band_hi    = btrr_pkg::UPPER_BOUND_RST;
      row_len    = btrr_pkg::ROW_WIDTH_RST;
      sparse_min = btrr_pkg::MIN_ROW_COUNT_RST;
      row_bits   = '0;
      col        = '0;
      hits       = '0;
      tot_in     = '0;
      tot_under  = '0;
      tot_over   = '0;
      fail_count = 0;
      row_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.row_mask    = out_tdata[0 +: MASK_W];
        seen.row_kept    = out_tdata[MASK_W +: COUNT_W];
        seen.row_cleared = out_tuser;
        seen.total_in    = out_tdata[MASK_W + COUNT_W +: TOTAL_W];
        seen.total_under = out_tdata[MASK_W + COUNT_W + TOTAL_W +: TOTAL_W];
        seen.total_over  = out_tdata[MASK_W + COUNT_W + 2 * TOTAL_W +: TOTAL_W];
        if (row_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected row transfer: expected none, got mask 0x%0h kept %0d",
                   $time, seen.row_mask, seen.row_kept);
        end else begin
          want = row_results.pop_front();
          check_field("row_mask", want.row_mask, seen.row_mask);
          check_field("row_kept", want.row_kept, seen.row_kept);
          check_field("row_cleared", want.row_cleared, seen.row_cleared);
          check_field("total_in", want.total_in, seen.total_in);
          check_field("total_under", want.total_under, seen.total_under);
          check_field("total_over", want.total_over, seen.total_over);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          btrr_pkg::REG_LOWER_BOUND:   band_lo    = cfg_wdata;
          btrr_pkg::REG_UPPER_BOUND:   band_hi    = cfg_wdata;
          btrr_pkg::REG_ROW_WIDTH:     row_len    = cfg_wdata[COUNT_W-1:0];
          btrr_pkg::REG_MIN_ROW_COUNT: sparse_min = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata, in_tuser);
    end
    pending = row_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIXEL_W     = btrr_pkg::PIXEL_W;
  localparam int COUNT_W     = btrr_pkg::COUNT_W;
  localparam int MASK_W      = btrr_pkg::MASK_W;
  localparam int OUT_DATA_W  = btrr_pkg::OUT_DATA_W;
  localparam int CFG_ADDR_W  = btrr_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = btrr_pkg::CFG_DATA_W;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIXEL_W-1:0]    in_tdata   = '0;   // pixel_value
  logic                  in_tuser   = 1'b0; // frame_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // row_mask, row_kept, total_in, total_under, total_over, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;         // row_cleared
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int fail_count;
  int pending;
  int cycles       = 0;
  int sent         = 0;
  int in_idle_pct  = 24;
  int out_idle_pct = 65;

  // stimulus-side copy of the band and row length, used to aim pixel values
  logic signed [PIXEL_W-1:0] cur_lo  = btrr_pkg::LOWER_BOUND_RST;
  logic signed [PIXEL_W-1:0] cur_hi  = btrr_pkg::UPPER_BOUND_RST;
  int                        cur_len = btrr_pkg::ROW_WIDTH_RST;

  band_threshold_row_reject_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  band_threshold_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Values on and next to both bounds, inside the band, at the extremes, or anywhere.
  function automatic logic [PIXEL_W-1:0] pick_pixel();
    longint span;
    span = longint'(cur_hi) - longint'(cur_lo) - 1;
    case ($urandom_range(9))
      0: return cur_lo;
      1: return cur_hi;
      2: return cur_lo + 1;
      3: return cur_hi - 1;
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      5, 6, 7: begin
        if (span > 0) return btrr_pkg::PIXEL_W'(longint'(cur_lo) + 1 + (longint'($urandom) % span));
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays up on return.
  task automatic send_pixel(input logic [PIXEL_W-1:0] v, input logic fs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (a)
      btrr_pkg::REG_LOWER_BOUND: cur_lo = d;
      btrr_pkg::REG_UPPER_BOUND: cur_hi = d;
      btrr_pkg::REG_ROW_WIDTH:   cur_len = (d[COUNT_W-1:0] == 0) ? 1 :
                                 ((d[COUNT_W-1:0] > MASK_W) ? MASK_W : int'(d[COUNT_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic set_band(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                          input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] m);
    write_reg(btrr_pkg::REG_LOWER_BOUND, lo);
    write_reg(btrr_pkg::REG_UPPER_BOUND, hi);
    write_reg(btrr_pkg::REG_ROW_WIDTH, w);
    write_reg(btrr_pkg::REG_MIN_ROW_COUNT, m);
  endtask

  // New settings, then whole rows with random content; frame starts mostly on row
  // boundaries, occasionally mid-row.
  task automatic run_segment();
    logic [CFG_DATA_W-1:0] lo, hi, w, m;
    int                    w_sel, eff, target, n;
    bit                    first;
    logic                  fs;
    w_sel = $urandom_range(99);
    if (w_sel < 55)      w = $urandom_range(1, 8);
    else if (w_sel < 80) w = $urandom_range(9, 32);
    else if (w_sel < 92) w = $urandom_range(33, 64);
    else if (w_sel < 96) w = 0;
    else                 w = $urandom_range(65, 127);
    eff = (w == 0) ? 1 : ((w > MASK_W) ? MASK_W : int'(w));
    case ($urandom_range(4))
      0:       m = 0;
      1:       m = 64;
      default: m = $urandom_range(0, (eff + 2 > 64) ? 64 : eff + 2);
    endcase
    case ($urandom_range(4))
      0: begin lo = 0; hi = 65536; end
      1: begin lo = $urandom; hi = $urandom; end
      2: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
      3: begin lo = $urandom; hi = lo + $urandom_range(2, 200000); end
      default: begin lo = $urandom; hi = lo; end
    endcase
    wait_idle();
    set_band(lo, hi, w, m);
    target = $urandom_range(30, 70);
    n      = 0;
    first  = 1'b1;
    while (n < target) begin
      for (int i = 0; i < cur_len; i++) begin
        fs = (i == 0 && $urandom_range(99) < (first ? 60 : 12)) || ($urandom_range(99) < 2);
        send_pixel(pick_pixel(), fs);
        n++;
      end
      first = 1'b0;
    end
  endtask

  initial begin
    int start;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // on both bounds and just inside; second row has one hit, below the minimum
    set_band(0, 65536, 4, 2);
    send_pixel(0, 1'b1);
    send_pixel(65536, 1'b0);
    send_pixel(1, 1'b0);
    send_pixel(65535, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h7fff_ffff, 1'b0);
    send_pixel(5, 1'b0);
    send_pixel(-1, 1'b0);

    // widest band, zero row width acts as one
    wait_idle();
    set_band(32'h8000_0000, 32'h7fff_ffff, 0, 0);
    send_pixel(32'h8000_0000, 1'b1);
    send_pixel(32'h7fff_ffff, 1'b0);
    send_pixel(0, 1'b0);

    // crossed bounds: nothing marked, empty row not cleared
    wait_idle();
    set_band(100, 50, 3, 2);
    send_pixel(75, 1'b1);
    send_pixel(150, 1'b0);
    send_pixel(100, 1'b0);

    // minimum above row width
    wait_idle();
    set_band(0, 65536, 3, 64);
    send_pixel(1, 1'b1);
    send_pixel(2, 1'b0);
    send_pixel(3, 1'b0);

    // row width shrinks mid-row, then a frame start mid-row
    wait_idle();
    write_reg(btrr_pkg::REG_ROW_WIDTH, 5);
    write_reg(btrr_pkg::REG_MIN_ROW_COUNT, 0);
    send_pixel(10, 1'b1);
    send_pixel(20, 1'b0);
    send_pixel(30, 1'b0);
    wait_idle();
    write_reg(btrr_pkg::REG_ROW_WIDTH, 2);
    send_pixel(40, 1'b0);
    send_pixel(50, 1'b0);
    send_pixel(60, 1'b1);
    send_pixel(70, 1'b0);

    for (int p = 0; p < 3; p++) begin
      in_idle_pct  = (p == 0) ? 24 : ((p == 1) ? 65 : 0);
      out_idle_pct = (p == 0) ? 65 : ((p == 1) ? 24 : 0);
      start = sent;
      while (sent - start < 275) run_segment();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
